FILE: hw/rtl/bsseg_pkg.sv
// Shared types, constants and functions for the binary to seven-segment block.
// Used by bsseg_cell and binary_to_seven_segment_blanked; depends on nothing.
package bsseg_pkg;

	localparam int VALUE_W     = 27;
	localparam int POS_W       = 3;
	localparam int SEG_W       = 8;
	localparam int S_DATA_W    = 32;
	localparam int M_DATA_W    = 16;
	localparam int DIGITS_DEF  = 8;
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = 35;
	localparam int PROD_W      = VALUE_W + RECIP_W;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

	// Exact floor(x / 10) for any x below 2**32: (x * RECIP) >> RECIP_SHIFT.
	localparam logic [RECIP_W-1:0] RECIP = 32'hCCCC_CCCD;

	localparam logic [SEG_W-1:0] BLANK = 8'hFF;

	// Token carried from one cell to the next.
	typedef struct packed {
		logic               valid;
		logic               ovf;
		logic [VALUE_W-1:0] quot;
	} bsseg_tok_t;

	// Result offered by one cell.
	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] pos;
		logic [SEG_W-1:0] segments;
		logic             ovf;
		logic             last;
	} bsseg_res_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
		logic [SEG_W-1:0] pat;
		unique case (digit)
			4'd0:    pat = 8'b0111_1110;
			4'd1:    pat = 8'b0000_0110;
			4'd2:    pat = 8'b0110_1101;
			4'd3:    pat = 8'b0100_1111;
			4'd4:    pat = 8'b0001_0111;
			4'd5:    pat = 8'b0101_1011;
			4'd6:    pat = 8'b0111_1011;
			4'd7:    pat = 8'b0000_1110;
			4'd8:    pat = 8'b0111_1111;
			4'd9:    pat = 8'b0101_1111;
			default: pat = BLANK;
		endcase
		return pat;
	endfunction

	// 10**n, evaluated at elaboration only.
	function automatic logic [63:0] pow10(input int n);
		logic [63:0] p;
		p = 64'd1;
		for (int k = 0; k < n; k++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

endpackage

FILE: hw/rtl/bsseg_cell.sv
// One digit cell of the chain: holds a quotient token, extracts its decimal digit,
// maps it to a segment pattern and hands the quotient / 10 to the next cell. Uses bsseg_pkg.
module bsseg_cell #(
	parameter int POS    = 0,
	parameter int DIGITS = bsseg_pkg::DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  bsseg_pkg::bsseg_tok_t tok_in,
	output bsseg_pkg::bsseg_tok_t tok_out,
	output bsseg_pkg::bsseg_res_t res
);

	logic                             valid_q;
	logic                             ovf_q;
	logic [bsseg_pkg::VALUE_W-1:0]    quot_q;
	logic [bsseg_pkg::PROD_W-1:0]     prod;
	logic [bsseg_pkg::QUOT_W-1:0]     q10;
	logic [3:0]                       rem;
	logic                             blank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ovf_q  <= tok_in.ovf;
			quot_q <= tok_in.quot;
		end
	end

	// Divide by ten through the reciprocal; the remainder needs only the low nibble.
	assign prod = bsseg_pkg::PROD_W'(quot_q) * bsseg_pkg::PROD_W'(bsseg_pkg::RECIP);
	assign q10  = prod[bsseg_pkg::PROD_W-1:bsseg_pkg::RECIP_SHIFT];
	assign rem  = quot_q[3:0] - ({q10[0], 3'b000} + {q10[2:0], 1'b0});

	// Nothing left above this position means a leading zero; the units digit always shows unless the value overflowed.
	assign blank = ovf_q || ((POS != 0) && (quot_q == '0));

	always_comb begin
		tok_out.valid = valid_q;
		tok_out.ovf   = ovf_q;
		tok_out.quot  = bsseg_pkg::VALUE_W'(q10);

		res.valid    = valid_q;
		res.pos      = bsseg_pkg::POS_W'(POS);
		res.segments = blank ? bsseg_pkg::BLANK : bsseg_pkg::seg_of(rem);
		res.ovf      = ovf_q;
		res.last     = (POS == DIGITS - 1);
	end

endmodule

FILE: hw/rtl/binary_to_seven_segment_blanked.sv
// Top level of the binary to seven-segment decoder with leading-zero blanking.
// Instantiates a chain of bsseg_cell; uses bsseg_pkg.
//
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tdata[26:0] value
// m_*      out  m_tvalid/m_tready   m_tdata: [2:0] digit_position, [10:3] segments,
//                                   [11] overflow; m_tlast = last
//
// Each value yields DIGITS items, units digit first, one per cycle while m_tready is high.
// A value walks the cell chain one cell per cycle while the chain advances;
// the next value waits in the input register and enters cell 0 as the last cell emits.
// An accepted value passes the input register, cell 0 and the output register before its first item appears.
// Reset clears all valid flags; patterns and quotients carry no reset.
// When m_tready is low while an item is waiting, the whole chain holds and the output register keeps its item.
module binary_to_seven_segment_blanked #(
	parameter int DIGITS = bsseg_pkg::DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bsseg_pkg::S_DATA_W-1:0]  s_tdata,   // [26:0] value, rest zero
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bsseg_pkg::M_DATA_W-1:0]  m_tdata,   // [2:0] digit_position,
	                                                   // [10:3] segments, [11] overflow
	output logic                            m_tlast
);

	// Values at or above this limit do not fit and show all blank.
	localparam logic [63:0] LIMIT = bsseg_pkg::pow10(DIGITS);
	localparam logic [bsseg_pkg::POS_W-1:0] LAST_POS = bsseg_pkg::POS_W'(DIGITS - 1);

	logic                             hold_valid_q;
	logic [bsseg_pkg::VALUE_W-1:0]    hold_value_q;
	logic                             advance;
	logic                             load0;
	logic [DIGITS-1:0]                cell_valid;
	bsseg_pkg::bsseg_tok_t            tok_in [DIGITS];
	bsseg_pkg::bsseg_res_t            res    [DIGITS];
	bsseg_pkg::bsseg_res_t            pick;
	logic                             m_valid_q;
	logic [bsseg_pkg::POS_W-1:0]      pos_q;
	logic [bsseg_pkg::SEG_W-1:0]      seg_q;
	logic                             ovf_q;
	logic                             last_q;

	// Advance the chain whenever the output register is free or being drained.
	assign advance = !m_valid_q || m_tready;

	// A new value enters cell 0 once no earlier cell still carries a token;
	// the last cell may be emitting in the same cycle.
	always_comb begin
		load0 = hold_valid_q && advance;
		for (int k = 0; k < DIGITS - 1; k++) begin
			if (cell_valid[k]) begin
				load0 = 1'b0;
			end
		end
	end

	assign s_tready = !hold_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			hold_valid_q <= 1'b1;
		end else if (load0) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hold_value_q <= s_tdata[bsseg_pkg::VALUE_W-1:0];
		end
	end

	always_comb begin
		tok_in[0].valid = load0;
		tok_in[0].ovf   = {37'd0, hold_value_q} >= LIMIT;
		tok_in[0].quot  = hold_value_q;
	end

	for (genvar k = 0; k < DIGITS; k++) begin : g_cell
		if (k < DIGITS - 1) begin : g_mid
			bsseg_cell #(
				.POS    (k),
				.DIGITS (DIGITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.advance (advance),
				.tok_in  (tok_in[k]),
				.tok_out (tok_in[k+1]),
				.res     (res[k])
			);
		end else begin : g_end
			bsseg_cell #(
				.POS    (k),
				.DIGITS (DIGITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.advance (advance),
				.tok_in  (tok_in[k]),
				.tok_out (),
				.res     (res[k])
			);
		end
		assign cell_valid[k] = res[k].valid;
	end

	// At most one cell holds a token, so an OR of the masked results selects it.
	always_comb begin
		pick = '0;
		for (int k = 0; k < DIGITS; k++) begin
			if (res[k].valid) begin
				pick = pick | res[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= |cell_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pos_q  <= pick.pos;
			seg_q  <= pick.segments;
			ovf_q  <= pick.ovf;
			last_q <= pick.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, ovf_q, seg_q, pos_q};
	assign m_tlast  = last_q;

`ifndef SYNTH
	// Only one value travels the chain at a time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_valid))
		else $error("more than one cell holds a token");

	// A value taken from the input register shows up in the first cell.
	a_load_enters: assert property (@(posedge clk) disable iff (!arst_n)
		load0 |=> cell_valid[0])
		else $error("loaded value did not reach cell 0");

	// The last flag marks the most significant position only.
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (last_q == (pos_q == LAST_POS)))
		else $error("last flag out of step with position");

	// An overflowed value shows blank on every position.
	a_ovf_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && ovf_q) |-> (seg_q == bsseg_pkg::BLANK))
		else $error("overflow item not blanked");
`endif

endmodule

FILE: dv/binary_to_seven_segment_blanked_test.sv
// Self-checking testbench for binary_to_seven_segment_blanked.
// Drives values on the slave stream and checks every digit item on the master stream
// against a local predictor; uses bsseg_pkg for widths and the blank pattern.
module binary_to_seven_segment_blanked_test;

	localparam int DIGITS      = bsseg_pkg::DIGITS_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN       = 24;
	localparam int RANDOM_CNT  = 440;
	localparam int CALM_FROM   = 1200;
	localparam int CALM_TO     = 2400;

	// Segment patterns for the decimal digits 0 to 9.
	localparam logic [bsseg_pkg::SEG_W-1:0] SEG_ROM [10] = '{
		8'h7E, 8'h06, 8'h6D, 8'h4F, 8'h17, 8'h5B, 8'h7B, 8'h0E, 8'h7F, 8'h5F
	};

	// One expected digit item on the master stream.
	typedef struct {
		logic [bsseg_pkg::VALUE_W-1:0] value;
		logic [bsseg_pkg::POS_W-1:0]   pos;
		logic [bsseg_pkg::SEG_W-1:0]   segments;
		logic                          ovf;
		logic                          last;
	} digit_item_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [bsseg_pkg::S_DATA_W-1:0] s_tdata  = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [bsseg_pkg::M_DATA_W-1:0] m_tdata;
	logic                           m_tlast;

	logic [bsseg_pkg::VALUE_W-1:0] values_pending [$];
	digit_item_t                   digits_due [$];
	int                            mismatches = 0;
	int                            cyc        = 0;
	int                            stall_cnt  = 0;
	logic                          calm;

	binary_to_seven_segment_blanked #(.DIGITS(DIGITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	// Both sides run without idling inside this window of cycles.
	assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	// Split a value into decimal digits, blank leading zeros from the top down,
	// and queue one expected item per display position, units digit first.
	task automatic predict_digits(input logic [bsseg_pkg::VALUE_W-1:0] value);
		logic [3:0]                  dig [DIGITS];
		logic [bsseg_pkg::SEG_W-1:0] pat [DIGITS];
		longint unsigned             rest;
		longint unsigned             limit;
		logic                        ovf;
		logic                        seen;
		digit_item_t                 item;
		rest  = value;
		limit = 1;
		seen  = 1'b0;
		for (int k = 0; k < DIGITS; k++) begin
			limit  = limit * 10;
			dig[k] = 4'(rest % 10);
			rest   = rest / 10;
		end
		ovf = (value >= limit);
		for (int k = DIGITS - 1; k >= 0; k--) begin
			if (ovf) begin
				pat[k] = bsseg_pkg::BLANK;
			end else if (seen || dig[k] != 0 || k == 0) begin
				pat[k] = SEG_ROM[dig[k]];
				seen   = 1'b1;
			end else begin
				pat[k] = bsseg_pkg::BLANK;
			end
		end
		for (int k = 0; k < DIGITS; k++) begin
			item.value    = value;
			item.pos      = bsseg_pkg::POS_W'(k);
			item.segments = pat[k];
			item.ovf      = ovf;
			item.last     = (k == DIGITS - 1);
			digits_due.push_back(item);
		end
	endtask

	// Count a mismatch; report only the first ten in detail.
	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("[%0d] digit check failed: %s", cyc, what);
		end
	endtask

	// Driver: hold the item while tready is low, advance on each handshake,
	// and insert random idle cycles outside the calm window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_digits(s_tdata[bsseg_pkg::VALUE_W-1:0]);
			end
			if (!s_tvalid || s_tready) begin
				if (values_pending.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= bsseg_pkg::S_DATA_W'(values_pending.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare every accepted digit item with the oldest prediction,
	// and drop tready at random outside the calm window.
	always @(posedge clk or negedge arst_n) begin
		digit_item_t                 want;
		logic [bsseg_pkg::POS_W-1:0] got_pos;
		logic [bsseg_pkg::SEG_W-1:0] got_seg;
		logic                        got_ovf;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_pos = m_tdata[bsseg_pkg::POS_W-1:0];
				got_seg = m_tdata[bsseg_pkg::POS_W +: bsseg_pkg::SEG_W];
				got_ovf = m_tdata[bsseg_pkg::POS_W + bsseg_pkg::SEG_W];
				if (digits_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected item pos=%0d seg=%02h ovf=%0b last=%0b",
						got_pos, got_seg, got_ovf, m_tlast));
				end else begin
					want = digits_due.pop_front();
					if (got_pos !== want.pos || got_seg !== want.segments
						|| got_ovf !== want.ovf || m_tlast !== want.last) begin
						flag_mismatch({
							$sformatf("value=%0d expected pos=%0d seg=%02h ovf=%0b last=%0b",
								want.value, want.pos, want.segments, want.ovf, want.last),
							$sformatf(", got pos=%0d seg=%02h ovf=%0b last=%0b",
								got_pos, got_seg, got_ovf, m_tlast)});
					end
				end
			end
			m_tready <= calm || ($urandom_range(99) >= 6);
		end
	end

	// Watchdog: end the run when nothing moves on either stream for too long.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cnt <= 0;
			end else if (stall_cnt >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
		end
	end

	initial begin
		int unsigned v;
		int unsigned pick;
		int unsigned nd;
		int unsigned p;
		// Directed values: zero, single digits, every power-of-ten boundary,
		// zeros inside the number, the overflow edge and the all-ones input.
		values_pending.push_back(bsseg_pkg::VALUE_W'(0));
		values_pending.push_back(bsseg_pkg::VALUE_W'(1));
		values_pending.push_back(bsseg_pkg::VALUE_W'(9));
		p = 10;
		for (int k = 1; k <= DIGITS; k++) begin
			values_pending.push_back(bsseg_pkg::VALUE_W'(p - 1));
			values_pending.push_back(bsseg_pkg::VALUE_W'(p));
			p = p * 10;
		end
		values_pending.push_back(bsseg_pkg::VALUE_W'(10000001));
		values_pending.push_back(bsseg_pkg::VALUE_W'(90807060));
		values_pending.push_back(bsseg_pkg::VALUE_W'(12345678));
		values_pending.push_back(bsseg_pkg::VALUE_W'(98765432));
		values_pending.push_back(bsseg_pkg::VALUE_W'(100000001));
		values_pending.push_back(bsseg_pkg::VALUE_W'((1 << bsseg_pkg::VALUE_W) - 1));
		values_pending.push_back(27'h5555555);
		values_pending.push_back(27'h2AAAAAA);
		// Random values, mostly in range with a spread of digit counts.
		for (int i = 0; i < RANDOM_CNT; i++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				nd = $urandom_range(DIGITS, 1);
				p  = 1;
				repeat (nd - 1) p = p * 10;
				v  = (nd == 1) ? $urandom_range(9) : $urandom_range(p * 10 - 1, p);
			end else if (pick < 65) begin
				// Sparse digits: a nonzero top digit over many zeros.
				nd = $urandom_range(DIGITS, 2);
				v  = $urandom_range(9, 1);
				for (int k = 1; k < nd; k++) begin
					v = v * 10 + ($urandom_range(1) ? 0 : $urandom_range(9));
				end
			end else if (pick < 80) begin
				v = $urandom_range((1 << bsseg_pkg::VALUE_W) - 1, 100000000);
			end else begin
				v = $urandom & ((1 << bsseg_pkg::VALUE_W) - 1);
			end
			values_pending.push_back(bsseg_pkg::VALUE_W'(v));
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// Sample on the falling edge so the queues and valid are settled.
		while (values_pending.size() != 0 || s_tvalid) @(negedge clk);
		while (digits_due.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
